@@ src/lcd_controller_vram_port_core_defines.svh @@
// Assertion macros shared by the checker of the LCD controller bus port.
`ifndef LCD_CONTROLLER_VRAM_PORT_CORE_DEFINES_SVH
`define LCD_CONTROLLER_VRAM_PORT_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LCDVP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcdvp check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LCDVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcdvp check failed");

`endif

@@ src/lcdvp_pkg.sv @@
// Geometry, register codes and helpers of the LCD controller bus port.
`timescale 1ns / 1ps
package lcdvp_pkg;

  localparam int SCREEN_WIDTH      = 192;
  localparam int COLUMN_LIMIT      = 22;
  localparam int ROW_LIMIT         = 64;
  localparam int ROWS_PER_BANK     = 32;
  localparam int BANK_PIXEL_OFFSET = 96;

  localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROWS_PER_BANK * ROW_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int ROW_W       = $clog2(ROWS_PER_BANK);
  localparam int BANK_MAX    = 255 / ROWS_PER_BANK;
  localparam int BANK_W      = $clog2(BANK_MAX + 2);

  // Bank number of an 8-bit Y comes from a reciprocal multiply and one correction.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / ROWS_PER_BANK;
  localparam int RECIP_W     = $clog2(RECIP + 1);

  // Signed first-pixel position of a column, lowest value is -4.
  localparam int BASE_MAX = BANK_MAX * BANK_PIXEL_OFFSET + 255 * 8;
  localparam int BASE_W   = $clog2(BASE_MAX + 1) + 1;
  localparam int COL_W    = BASE_W - 3;

  localparam int MODE_W = 5;
  localparam int CS_W   = 6;

  localparam int CTRL_SIX_BIT  = 6;
  localparam int CTRL_XINC_BIT = 7;

  // Register selector codes taken from the index register's low bits.
  localparam logic [2:0] SEL_DATA = 3'd0;
  localparam logic [2:0] SEL_X    = 3'd1;
  localparam logic [2:0] SEL_Y    = 3'd2;
  localparam logic [2:0] SEL_CTRL = 3'd3;
  localparam logic [2:0] SEL_MODE = 3'd4;
  localparam logic [2:0] SEL_CS   = 3'd5;

  // Items that may be in flight between the input and output handshakes.
  localparam int MAX_OUTSTANDING = 2;

  // Mask of the on-screen pixels of one byte column, MSB leftmost.
  function automatic logic [7:0] col_mask(input logic signed [COL_W-1:0] c);
    int lim;
    logic [7:0] m;
    m = 8'h00;
    if (c >= 0 && c < ROW_BYTES) begin
      lim = SCREEN_WIDTH - (int'(c) * 8);
      if (lim >= 8) begin
        m = 8'hFF;
      end else begin
        m = ~(8'hFF >> lim[2:0]);
      end
    end
    return m;
  endfunction

endpackage

@@ src/lcdvp_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module lcdvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lcd_controller_vram_port_core.sv @@
// Top level of the LCD controller byte bus port with its bitmap store.
`timescale 1ns / 1ps
// Each accepted item is one bus access. Register accesses, status column
// accesses and data accesses outside the pixel columns pass through an
// execute state and a result state before the next item can be taken; a
// pixel column access adds the bank and row split of Y, the column position,
// and the read of two bytes through the single store memory, and a write
// then writes the changed bytes back. The result of an item sits in an output
// register, so the next item is taken while it waits. After reset the store
// is cleared one byte per cycle, all STORE_BYTES (768) bytes, and no item is
// taken until that is done.
module lcd_controller_vram_port_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic       port_sel_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o
);
  import lcdvp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_DIV, S_GEO, S_RD0, S_RD1, S_MOD, S_WR1, S_RESP
  } state_e;

  localparam logic [7:0]         COL_LIMIT_C = 8'(COLUMN_LIMIT);
  localparam logic [7:0]         ROW_LIMIT_C = 8'(ROW_LIMIT);
  localparam logic [7:0]         RPB_C       = 8'(ROWS_PER_BANK);
  localparam logic [RECIP_W-1:0] RECIP_C     = RECIP_W'(RECIP);
  localparam logic [BASE_W-1:0]  BPO_C       = BASE_W'(BANK_PIXEL_OFFSET);
  localparam logic [ADDR_W-1:0]  ROW_BYTES_C = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0]  CLR_LAST_C  = ADDR_W'(STORE_BYTES - 1);

  state_e state_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [7:0] index_q, x_q, y_q, ctrl_q, status_q;
  logic [MODE_W-1:0] mode_q;
  logic [CS_W-1:0] cs_q;
  logic out_valid_q;
  logic [7:0] out_data_q;

  // Datapath registers of the item in progress.
  logic wr_q, port_q;
  logic [7:0] wdata_q, res_q;
  logic [7:0] pix_y_q, pix_xoff_q;
  logic six_q;
  logic [BANK_W-1:0] q_q, bank_q;
  logic [ROW_W-1:0] row_q;
  logic [BASE_W-1:0] base_q;
  logic [2:0] off_q;
  logic [7:0] mask0_q, mask1_q, byte0_q, new1_q;
  logic [ADDR_W-1:0] addr0_q, addr1_q;
  logic we1_q;

  logic in_fire, out_fire;
  logic six, is_status, is_pixel;
  logic [7:0] first_col, status_col, stat_mask, stat_new, exec_rd;
  logic [8+RECIP_W-1:0] q_prod;
  logic [BANK_W+7:0] q_mul;
  logic [7:0] rem_est;
  logic rem_fix;
  logic [BASE_W-1:0] base_u, base_calc;
  logic signed [COL_W-1:0] col0, col1;
  logic [7:0] cmask0, cmask1;
  logic [ADDR_W-1:0] addr0, addr1;
  logic [15:0] win_valid, old_win, rd_win, pix_mask, wr_win, upd_mask, new_win;
  logic [7:0] acc;
  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign out_fire    = out_valid_q && out_ready_i;

  // Decode of a data access against the current registers.
  always_comb begin
    six        = ctrl_q[CTRL_SIX_BIT];
    status_col = six ? 8'd5 : 8'd3;
    first_col  = six ? 8'd6 : 8'd4;
    is_status  = (x_q == status_col);
    is_pixel   = (x_q >= first_col) && (x_q < COL_LIMIT_C) && (y_q < ROW_LIMIT_C);
    stat_mask  = 8'h01 << y_q[4:2];
    stat_new   = status_q;
    if (wr_q) begin
      stat_new = (wdata_q != 8'h00) ? (status_q | stat_mask) : (status_q & ~stat_mask);
    end
    q_prod = y_q * RECIP_C;
  end

  always_comb begin
    exec_rd = 8'h00;
    if (!port_q) begin
      exec_rd = index_q;
    end else begin
      case (index_q[2:0])
        SEL_DATA: exec_rd = is_status ? (stat_new & stat_mask) : x_q;
        SEL_X:    exec_rd = x_q;
        SEL_Y:    exec_rd = y_q;
        SEL_CTRL: exec_rd = ctrl_q;
        SEL_MODE: exec_rd = 8'(mode_q);
        SEL_CS:   exec_rd = 8'(cs_q);
        default:  exec_rd = 8'h00;
      endcase
    end
  end

  // Bank and row, then the first pixel and the two store bytes it touches.
  always_comb begin
    q_mul     = q_q * RPB_C;
    rem_est   = pix_y_q - q_mul[7:0];
    rem_fix   = (rem_est >= RPB_C);
    base_u    = BASE_W'(bank_q) * BPO_C
              + (six_q ? BASE_W'(pix_xoff_q) * BASE_W'(6) : BASE_W'(pix_xoff_q) * BASE_W'(8));
    base_calc = six_q ? base_u : base_u - BASE_W'(4);
    col0      = $signed(base_q[BASE_W-1:3]);
    col1      = col0 + COL_W'(1);
    cmask0    = col_mask(col0);
    cmask1    = col_mask(col1);
    addr0     = (cmask0 != 8'h00) ? ADDR_W'(row_q) * ROW_BYTES_C + ADDR_W'(col0) : '0;
    addr1     = (cmask1 != 8'h00) ? ADDR_W'(row_q) * ROW_BYTES_C + ADDR_W'(col1) : '0;
  end

  // Pixel window over the two bytes; pixel i of the item sits at off_q + i.
  always_comb begin
    win_valid = {mask0_q, mask1_q};
    old_win   = {byte0_q, ram_rdata};
    rd_win    = (old_win & win_valid) << off_q;
    acc       = six_q ? {2'b00, rd_win[15:10]} : rd_win[15:8];
    pix_mask  = {(six_q ? 8'hFC : 8'hFF), 8'h00} >> off_q;
    wr_win    = {(six_q ? {wdata_q[5:0], 2'b00} : wdata_q), 8'h00} >> off_q;
    upd_mask  = pix_mask & win_valid;
    new_win   = (old_win & ~upd_mask) | (wr_win & upd_mask);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr1_q;
    ram_wdata = new1_q;
    ram_raddr = addr1_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = 8'h00;
      end
      S_RD0: ram_raddr = addr0;
      S_MOD: begin
        ram_we    = wr_q && (upd_mask[15:8] != 8'h00);
        ram_waddr = addr0_q;
        ram_wdata = new_win[15:8];
      end
      S_WR1: ram_we = we1_q;
      default: ;
    endcase
  end

  lcdvp_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      index_q     <= 8'h00;
      x_q         <= 8'h00;
      y_q         <= 8'h00;
      ctrl_q      <= 8'h00;
      mode_q      <= '0;
      cs_q        <= '0;
      status_q    <= 8'h00;
      out_valid_q <= 1'b0;
      out_data_q  <= 8'h00;
    end else begin
      // A result leaving in the same cycle as a new one is loaded is handled in S_RESP.
      if (out_fire && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
          if (clr_cnt_q == CLR_LAST_C) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_RESP;
          if (!port_q) begin
            if (wr_q) begin
              index_q <= wdata_q;
            end
          end else begin
            case (index_q[2:0])
              SEL_DATA: begin
                if (is_status) begin
                  status_q <= stat_new;
                end else if (is_pixel) begin
                  state_q <= S_DIV;
                end
                if (wr_q) begin
                  if (ctrl_q[CTRL_XINC_BIT]) begin
                    x_q <= x_q + 8'd1;
                  end else begin
                    y_q <= y_q + 8'd1;
                  end
                end
              end
              SEL_X:    if (wr_q) x_q <= wdata_q;
              SEL_Y:    if (wr_q) y_q <= wdata_q;
              SEL_CTRL: if (wr_q) ctrl_q <= wdata_q;
              SEL_MODE: if (wr_q) mode_q <= wdata_q[MODE_W-1:0];
              SEL_CS:   if (wr_q) cs_q <= wdata_q[CS_W-1:0];
              default: ;
            endcase
          end
        end
        S_DIV: state_q <= S_GEO;
        S_GEO: state_q <= S_RD0;
        S_RD0: state_q <= S_RD1;
        S_RD1: state_q <= S_MOD;
        S_MOD: state_q <= wr_q ? S_WR1 : S_RESP;
        S_WR1: state_q <= S_RESP;
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          wr_q    <= req_type_i;
          port_q  <= port_sel_i;
          wdata_q <= write_data_i;
        end
      end
      S_EXEC: begin
        res_q      <= wr_q ? 8'h00 : exec_rd;
        pix_y_q    <= y_q;
        pix_xoff_q <= x_q - first_col;
        six_q      <= six;
        q_q        <= q_prod[RECIP_SHIFT +: BANK_W];
      end
      S_DIV: begin
        bank_q <= rem_fix ? q_q + BANK_W'(1) : q_q;
        row_q  <= rem_fix ? ROW_W'(rem_est - RPB_C) : ROW_W'(rem_est);
      end
      S_GEO: base_q <= base_calc;
      S_RD0: begin
        off_q   <= base_q[2:0];
        mask0_q <= cmask0;
        mask1_q <= cmask1;
        addr0_q <= addr0;
        addr1_q <= addr1;
      end
      S_RD1: byte0_q <= ram_rdata;
      S_MOD: begin
        new1_q <= new_win[7:0];
        we1_q  <= wr_q && (upd_mask[7:0] != 8'h00);
        res_q  <= wr_q ? 8'h00 : acc;
      end
      default: ;
    endcase
  end

endmodule

@@ src/lcdvp_checker.sv @@
// Port-level checker of the LCD controller bus port, bound to the top level.
`timescale 1ns / 1ps
`include "lcd_controller_vram_port_core_defines.svh"
module lcdvp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       req_type_i,
  input logic       port_sel_i,
  input logic [7:0] write_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o
);
  import lcdvp_pkg::*;

  logic in_fire, out_fire;
  logic [1:0] cnt_q, pos;
  logic head_wr_q, tail_wr_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign pos      = cnt_q - 2'(out_fire);

  // Tracks which outstanding items were writes, oldest first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 2'd0;
      head_wr_q <= 1'b0;
      tail_wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(in_fire) - 2'(out_fire);
      if (in_fire && pos == 2'd0) begin
        head_wr_q <= req_type_i;
      end else if (out_fire) begin
        head_wr_q <= tail_wr_q;
      end
      if (in_fire && pos != 2'd0) begin
        tail_wr_q <= req_type_i;
      end
    end
  end

  `LCDVP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(read_data_o))
  `LCDVP_ASSERT_IMP(a_in_flight_bound, 1'b1, cnt_q <= 2'(MAX_OUTSTANDING))
  `LCDVP_ASSERT_IMP(a_no_spurious_item, out_valid_o, cnt_q != 2'd0)
  `LCDVP_ASSERT_IMP(a_write_reads_zero, out_valid_o && head_wr_q, read_data_o == 8'd0)

endmodule

bind lcd_controller_vram_port_core lcdvp_checker u_checker (.*);

@@ bench/lcd_controller_vram_port_core_test.sv @@
// Self-checking bench for the LCD controller byte bus port, predicted against its own model.
`timescale 1ns / 1ps
module lcd_controller_vram_port_core_test;
  import lcdvp_pkg::*;

  localparam int CLK_PERIOD_NS = 20;
  localparam int RESET_CYCLES  = 11;
  localparam int LIMIT_CYCLES  = 600_000;
  localparam int SETTLE_CYCLES = 20;

  localparam int ACCESS_TARGET    = 1975;
  localparam int QUIET_TAIL       = 250;
  localparam int LONG_HOLD_AT     = 500;
  localparam int LONG_HOLD_CYCLES = 300;

  localparam logic REQ_READ   = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_REG   = 1'b1;

  // Selector codes that reach no register.
  localparam logic [2:0] SEL_SPARE_LO = 3'd6;
  localparam logic [2:0] SEL_SPARE_HI = 3'd7;

  localparam int STATUS_COL_SIX   = 5;
  localparam int STATUS_COL_EIGHT = 3;
  localparam int FIRST_COL_SIX    = 6;
  localparam int FIRST_COL_EIGHT  = 4;
  localparam int EIGHT_PIXEL_SKEW = 4;

  typedef struct {
    logic        wr;
    logic        port;
    logic [7:0]  data;
    int unsigned gap;
    bit          drain;
  } bus_access_t;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       req_type = 1'b0;
  logic       port_sel = 1'b0;
  logic [7:0] write_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;

  lcd_controller_vram_port_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .port_sel_i   (port_sel),
    .write_data_i (write_data),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data)
  );

  always #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;

  // Predicted state of the port.
  logic [7:0]      index_q   = 8'h00;
  logic [7:0]      x_q       = 8'h00;
  logic [7:0]      y_q       = 8'h00;
  logic [7:0]      control_q = 8'h00;
  logic [MODE_W-1:0] mode_q  = '0;
  logic [CS_W-1:0] cs_q      = '0;
  logic [7:0]      status_q  = 8'h00;
  logic [7:0]      lcd_bitmap [STORE_BYTES];

  bus_access_t pending_accesses[$];
  logic [7:0]  read_data_due[$];

  int  fail_count = 0;
  int  results_seen = 0;
  int  total_accesses = 0;
  bit  sender_idles = 1'b0;
  bit  drain_next = 1'b0;

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("MISMATCH result %0d: %s expected 0x%02h got 0x%02h",
             results_seen, what, want, got);
    fail_count++;
  endtask

  // Applies one bus access to the predicted state and returns the byte read.
  function automatic logic [7:0] bus_access_result(bus_access_t a);
    logic [7:0] r;
    logic [7:0] m;
    bit         wr;
    bit         six;
    int         status_col;
    int         first_col;
    int         npix;
    int         base;
    int         row;
    int         px;
    int         idx;
    int         bitpos;
    r = 8'h00;
    wr = (a.wr == REQ_WRITE);
    if (a.port == PORT_INDEX) begin
      if (wr) index_q = a.data;
      else r = index_q;
    end else begin
      case (index_q[2:0])
        SEL_DATA: begin
          six = control_q[CTRL_SIX_BIT];
          status_col = six ? STATUS_COL_SIX : STATUS_COL_EIGHT;
          first_col = six ? FIRST_COL_SIX : FIRST_COL_EIGHT;
          npix = six ? 6 : 8;
          r = x_q;
          if (int'(x_q) == status_col) begin
            m = 8'h01 << y_q[4:2];
            if (wr) status_q = (a.data != 8'h00) ? (status_q | m) : (status_q & ~m);
            r = status_q & m;
          end else if (int'(x_q) >= first_col && int'(x_q) < COLUMN_LIMIT &&
                       int'(y_q) < ROW_LIMIT) begin
            row = int'(y_q) % ROWS_PER_BANK;
            base = (int'(y_q) / ROWS_PER_BANK) * BANK_PIXEL_OFFSET +
                   (int'(x_q) - first_col) * npix;
            if (!six) base = base - EIGHT_PIXEL_SKEW;
            r = 8'h00;
            for (int i = 0; i < npix; i++) begin
              px = base + i;
              bitpos = npix - 1 - i;
              // Pixels off either side of the screen are dropped and read as zero.
              if (px >= 0 && px < SCREEN_WIDTH) begin
                idx = row * ROW_BYTES + px / 8;
                if (wr) lcd_bitmap[idx][7 - px % 8] = a.data[bitpos];
                else r[bitpos] = lcd_bitmap[idx][7 - px % 8];
              end
            end
          end
          if (wr) begin
            if (control_q[CTRL_XINC_BIT]) x_q = x_q + 8'd1;
            else y_q = y_q + 8'd1;
          end
        end
        SEL_X:    if (wr) x_q = a.data; else r = x_q;
        SEL_Y:    if (wr) y_q = a.data; else r = y_q;
        SEL_CTRL: if (wr) control_q = a.data; else r = control_q;
        SEL_MODE: if (wr) mode_q = a.data[MODE_W-1:0]; else r = 8'(mode_q);
        SEL_CS:   if (wr) cs_q = a.data[CS_W-1:0]; else r = 8'(cs_q);
        default:  r = 8'h00;
      endcase
    end
    if (wr) r = 8'h00;
    return r;
  endfunction

  task automatic queue_access(input logic wr, input logic port, input logic [7:0] data);
    bus_access_t a;
    a.wr = wr;
    a.port = port;
    a.data = data;
    a.gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    a.drain = drain_next;
    drain_next = 1'b0;
    pending_accesses.push_back(a);
  endtask

  // Upper index bits are don't-care, so they are randomized.
  task automatic point_index(input logic [2:0] sel);
    logic [7:0] v;
    v = 8'($urandom);
    v[2:0] = sel;
    queue_access(REQ_WRITE, PORT_INDEX, v);
  endtask

  task automatic set_reg(input logic [2:0] sel, input logic [7:0] v);
    point_index(sel);
    queue_access(REQ_WRITE, PORT_REG, v);
  endtask

  task automatic get_reg(input logic [2:0] sel);
    point_index(sel);
    queue_access(REQ_READ, PORT_REG, 8'h00);
  endtask

  // Sender: offers the pending items in order, with gaps and drain pauses.
  int unsigned gap_cycles = 0;
  always @(posedge clk_i) begin
    bit offer;
    if (rst_n) begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        read_data_due.push_back(bus_access_result(pending_accesses[0]));
        void'(pending_accesses.pop_front());
        offer = 1'b0;
      end
      if (!offer && pending_accesses.size() != 0) begin
        if (gap_cycles < pending_accesses[0].gap) begin
          gap_cycles++;
        end else if (!(pending_accesses[0].drain && read_data_due.size() != 0)) begin
          offer = 1'b1;
          gap_cycles = 0;
          req_type <= pending_accesses[0].wr;
          port_sel <= pending_accesses[0].port;
          write_data <= pending_accesses[0].data;
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver: checks each result and stalls in bursts, once for a long stretch.
  int  hold_left = 0;
  int  stall_left = 0;
  bit  stalls_on = 1'b1;
  always @(posedge clk_i) begin
    logic [7:0] want;
    bit         rdy;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (read_data_due.size() == 0) begin
          report_mismatch("result with no access pending", 8'h00, read_data);
        end else begin
          want = read_data_due.pop_front();
          if (read_data !== want) report_mismatch("read_data", want, read_data);
        end
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
        if (results_seen % 128 == 0) stalls_on = 1'($urandom_range(0, 1));
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (stalls_on && results_seen + QUIET_TAIL < total_accesses &&
                   $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  initial begin
    #(CLK_PERIOD_NS * LIMIT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0] ctrl;
    logic [7:0] x0;
    logic [7:0] y0;
    bit         six;
    int         n;
    int         count;
    int         chunk;

    foreach (lcd_bitmap[i]) lcd_bitmap[i] = 8'h00;

    // Directed: index and spare selectors, register masking, status and clipping.
    queue_access(REQ_READ, PORT_INDEX, 8'h00);
    queue_access(REQ_WRITE, PORT_INDEX, {5'h1F, SEL_SPARE_HI});
    queue_access(REQ_WRITE, PORT_REG, 8'hAA);
    queue_access(REQ_READ, PORT_REG, 8'h00);
    queue_access(REQ_READ, PORT_INDEX, 8'h00);
    set_reg(SEL_MODE, 8'hFF);
    queue_access(REQ_READ, PORT_REG, 8'h00);
    set_reg(SEL_CS, 8'hFF);
    queue_access(REQ_READ, PORT_REG, 8'h00);
    set_reg(SEL_CTRL, 8'hC0);
    set_reg(SEL_X, 8'(STATUS_COL_SIX));
    set_reg(SEL_Y, 8'h1C);
    point_index(SEL_DATA);
    queue_access(REQ_WRITE, PORT_REG, 8'h01);
    queue_access(REQ_WRITE, PORT_REG, 8'hFF);
    queue_access(REQ_READ, PORT_REG, 8'h00);
    set_reg(SEL_CTRL, 8'h00);
    set_reg(SEL_X, 8'(FIRST_COL_EIGHT));
    point_index(SEL_DATA);
    queue_access(REQ_WRITE, PORT_REG, 8'hFF);
    queue_access(REQ_READ, PORT_REG, 8'h00);

    // Random: mostly well-formed pixel and status sequences, some noise.
    chunk = -1;
    while (pending_accesses.size() < ACCESS_TARGET) begin
      n = pending_accesses.size();
      if (n / 100 != chunk) begin
        chunk = n / 100;
        sender_idles = $urandom_range(0, 2) != 0;
        if (chunk == 7 || chunk == 13) drain_next = 1'b1;
      end
      if ((n > 400 && n < 650) || n + QUIET_TAIL >= ACCESS_TARGET) sender_idles = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          ctrl = 8'($urandom);
          six = ctrl[CTRL_SIX_BIT];
          x0 = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
               8'($urandom_range(0, COLUMN_LIMIT + 1));
          y0 = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
               8'($urandom_range(0, ROW_LIMIT + 3));
          count = $urandom_range(2, 8);
          set_reg(SEL_CTRL, ctrl);
          set_reg(SEL_X, x0);
          set_reg(SEL_Y, y0);
          point_index(SEL_DATA);
          for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) queue_access(REQ_READ, PORT_REG, 8'($urandom));
            else queue_access(REQ_WRITE, PORT_REG,
                              ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
          end
          // Sometimes read back at the start position of what was just written.
          if ($urandom_range(0, 1) == 1) begin
            set_reg(SEL_X, x0);
            set_reg(SEL_Y, y0);
            point_index(SEL_DATA);
            for (int i = 0; i < count; i++) queue_access(REQ_READ, PORT_REG, 8'($urandom));
          end
        end
        5: begin
          if ($urandom_range(0, 1) == 1) set_reg(3'($urandom), 8'($urandom));
          else get_reg(3'($urandom));
        end
        6: queue_access(1'($urandom_range(0, 1)), PORT_INDEX, 8'($urandom));
        7: begin
          count = $urandom_range(1, 4);
          for (int i = 0; i < count; i++)
            queue_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom));
        end
        8: begin
          ctrl = 8'($urandom);
          six = ctrl[CTRL_SIX_BIT];
          set_reg(SEL_CTRL, ctrl);
          set_reg(SEL_X, six ? 8'(STATUS_COL_SIX) : 8'(STATUS_COL_EIGHT));
          set_reg(SEL_Y, 8'($urandom));
          point_index(SEL_DATA);
          count = $urandom_range(1, 4);
          for (int i = 0; i < count; i++) begin
            queue_access(1'($urandom_range(0, 1)), PORT_REG,
                         ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
          end
        end
        default: begin
          get_reg(SEL_X);
          get_reg(SEL_Y);
          get_reg(SEL_CTRL);
          get_reg(SEL_MODE);
          get_reg(SEL_CS);
          get_reg(SEL_SPARE_LO);
        end
      endcase
    end
    total_accesses = pending_accesses.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_accesses.size() != 0 || read_data_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
